// ===== src/fat32_tsp_pkg.sv =====
`default_nettype none
package fat32_tsp_pkg;

	// Field widths, fixed by the FAT32 boot sector layout.
	localparam int TOTAL_W = 32;
	localparam int SPC_W   = 8;
	localparam int RSV_W   = 16;
	localparam int COPY_W  = 8;
	localparam int CLUS_W  = 28;

	// Table geometry: 4-byte entries in 512-byte sectors, two reserved entries.
	localparam int SECTOR_BYTES        = 512;
	localparam int ENTRY_BYTES         = 4;
	localparam int RESERVED_ENTRIES    = 2;
	localparam int ENTRIES_PER_SECTOR  = SECTOR_BYTES / ENTRY_BYTES;
	localparam int ENT_SHIFT           = $clog2(ENTRIES_PER_SECTOR);
	localparam int ENTRY_PAD           = RESERVED_ENTRIES + ENTRIES_PER_SECTOR - 1;

	// Sectors per FAT copy: enough for the largest legal cluster count.
	localparam int FAT_W = CLUS_W + 1 - ENT_SHIFT;

	// Widths of the intermediate values.
	localparam int PROD_W = COPY_W + FAT_W;
	localparam int META_W = ((PROD_W > RSV_W) ? PROD_W : RSV_W) + 1;

	// Largest legal cluster count.
	localparam logic [CLUS_W-1:0] CLUSTER_LIMIT = 28'hFFFFFF5;

	// Iteration limit and counter widths.
	localparam int MAX_ROUNDS = 64;
	localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
	localparam int CNT_W      = $clog2(TOTAL_W);

endpackage
`default_nettype wire

// ===== src/fat32_tsp_in_if.sv =====
`default_nettype none
interface fat32_tsp_in_if;
	import fat32_tsp_pkg::*;

	logic                valid;
	logic                ready;
	logic [TOTAL_W-1:0]  vol_sectors;
	logic [SPC_W-1:0]    clus_sectors;
	logic [RSV_W-1:0]    rsv_sectors;
	logic [COPY_W-1:0]   copy_count;

	modport source (
		output valid, vol_sectors, clus_sectors, rsv_sectors, copy_count,
		input  ready
	);

	modport sink (
		input  valid, vol_sectors, clus_sectors, rsv_sectors, copy_count,
		output ready
	);

endinterface
`default_nettype wire

// ===== src/fat32_tsp_out_if.sv =====
`default_nettype none
interface fat32_tsp_out_if;
	import fat32_tsp_pkg::*;

	logic               valid;
	logic               ready;
	logic               plan_ok;
	logic [FAT_W-1:0]   table_sectors;
	logic [CLUS_W-1:0]  cluster_count;

	modport source (
		output valid, plan_ok, table_sectors, cluster_count,
		input  ready
	);

	modport sink (
		input  valid, plan_ok, table_sectors, cluster_count,
		output ready
	);

endinterface
`default_nettype wire

// ===== src/fat32_table_size_planner_unit.sv =====
`default_nettype none
// FAT32 table size planner. A request carries the volume's total sectors,
// sectors per cluster, reserved sectors and FAT copy count; the response gives
// the sectors per FAT copy and the data cluster count, or plan_ok low with
// both fields zero when the volume cannot be planned. Starting from a guess of
// one FAT sector, each round runs a bit-serial multiply of the copy count by
// the guess, subtracts the metadata, runs a one-bit-per-cycle restoring
// divider for the cluster count and then checks the table need. A request
// usually takes two or three rounds and at most 64; a zero cluster size,
// reserved count or copy count is answered without a round, and other
// failures end at the round in which they appear. A new request is taken
// while the previous response still waits in the output register.
module fat32_table_size_planner_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	fat32_tsp_in_if.sink       req,
	fat32_tsp_out_if.source    rsp
);
	import fat32_tsp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_META,
		ST_DIV,
		ST_CHECK,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [SPC_W-1:0]    spc_q;
	logic [RSV_W-1:0]    rsv_q;
	logic [COPY_W-1:0]   copy_sh_q;
	logic [COPY_W-1:0]   copies_q;
	logic [FAT_W-1:0]    guess_q;
	logic [PROD_W-1:0]   prod_q;
	logic [TOTAL_W-1:0]  dq_q;
	logic [SPC_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ROUND_W-1:0]  round_q;
	logic                res_ok_q;
	logic [FAT_W-1:0]    res_fat_q;
	logic [CLUS_W-1:0]   res_clus_q;
	logic                out_valid_q;
	logic                out_ok_q;
	logic [FAT_W-1:0]    out_fat_q;
	logic [CLUS_W-1:0]   out_clus_q;

	logic [PROD_W-1:0]   prod_next;
	logic [META_W-1:0]   meta;
	logic                no_room;
	logic [SPC_W:0]      trial;
	logic                trial_ge;
	logic [SPC_W:0]      trial_diff;
	logic                clus_bad;
	logic [CLUS_W:0]     need_sum;
	logic [FAT_W-1:0]    need;
	logic                in_xfer;
	logic                out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid         = out_valid_q;
	assign rsp.plan_ok       = out_ok_q;
	assign rsp.table_sectors = out_fat_q;
	assign rsp.cluster_count = out_clus_q;

	// Shift-and-add multiply step, copy count taken most significant bit first.
	always_comb begin
		prod_next = {prod_q[PROD_W-2:0], 1'b0};
		if (copy_sh_q[COPY_W-1]) begin
			prod_next = prod_next + PROD_W'(guess_q);
		end
	end

	// Metadata sectors and the room check.
	assign meta    = META_W'(rsv_q) + META_W'(prod_q);
	assign no_room = TOTAL_W'(meta) >= total_q;

	// Restoring division step: one quotient bit shifts into the dividend word.
	assign trial      = {rem_q, dq_q[TOTAL_W-1]};
	assign trial_ge   = trial >= {1'b0, spc_q};
	assign trial_diff = trial - {1'b0, spc_q};

	// Cluster range check and the sectors that the table needs.
	assign clus_bad = (dq_q == '0) || (dq_q > TOTAL_W'(CLUSTER_LIMIT));
	assign need_sum = {1'b0, dq_q[CLUS_W-1:0]} + (CLUS_W+1)'(ENTRY_PAD);
	assign need     = need_sum[CLUS_W:ENT_SHIFT];

	// Sequencer, datapath registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A response leaving while none is loaded empties the output register.
			if (out_valid_q && rsp.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						total_q    <= req.vol_sectors;
						spc_q      <= req.clus_sectors;
						rsv_q      <= req.rsv_sectors;
						copies_q   <= req.copy_count;
						copy_sh_q  <= req.copy_count;
						guess_q    <= FAT_W'(1);
						prod_q     <= '0;
						cnt_q      <= '0;
						round_q    <= '0;
						res_ok_q   <= 1'b0;
						res_fat_q  <= '0;
						res_clus_q <= '0;
						if (req.clus_sectors == '0 || req.rsv_sectors == '0 ||
						    req.copy_count == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q    <= prod_next;
					copy_sh_q <= {copy_sh_q[COPY_W-2:0], 1'b0};
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(COPY_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_META;
					end
				end
				ST_META: begin
					if (no_room) begin
						state_q <= ST_FIN;
					end else begin
						dq_q    <= total_q - TOTAL_W'(meta);
						rem_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? trial_diff[SPC_W-1:0] : trial[SPC_W-1:0];
					dq_q  <= {dq_q[TOTAL_W-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TOTAL_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (clus_bad) begin
						state_q <= ST_FIN;
					end else if (need <= guess_q) begin
						res_ok_q   <= 1'b1;
						res_fat_q  <= guess_q;
						res_clus_q <= dq_q[CLUS_W-1:0];
						state_q    <= ST_FIN;
					end else if (round_q == ROUND_W'(MAX_ROUNDS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						guess_q   <= need;
						round_q   <= round_q + 1'b1;
						prod_q    <= '0;
						copy_sh_q <= copies_q;
						state_q   <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= res_ok_q;
						out_fat_q   <= res_fat_q;
						out_clus_q  <= res_clus_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
